/* rtl/fbrf_pkg.sv */
package fbrf_pkg;

	// Default screen geometry.
	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;

	// Field widths of a command and a response.
	localparam int OP_W    = 2;
	localparam int X_W     = 10;
	localparam int Y_W     = 9;
	localparam int COLOR_W = 32;

	// Width of internal coordinates and limits; holds any screen dimension up to 8191.
	localparam int DIM_W = 13;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_NONE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [X_W-1:0]     left_x;
		logic [Y_W-1:0]     top_y;
		logic [X_W-1:0]     right_x;
		logic [Y_W-1:0]     bottom_y;
		logic [COLOR_W-1:0] fill_color;
	} cmd_t;

	typedef struct packed {
		logic               command_done;
		logic [COLOR_W-1:0] read_color;
	} rsp_t;

endpackage

/* rtl/fbrf_mem.sv */
module fbrf_mem #(
	parameter int DEPTH = fbrf_pkg::SCREEN_WIDTH_DEF * fbrf_pkg::SCREEN_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                addr,
	input  logic [fbrf_pkg::COLOR_W-1:0] wdata,
	output logic [fbrf_pkg::COLOR_W-1:0] rdata
);

	logic [fbrf_pkg::COLOR_W-1:0] mem [DEPTH];
	logic [fbrf_pkg::COLOR_W-1:0] rdata_q;

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/fbrf_seq.sv */
module fbrf_seq #(
	parameter int SCREEN_WIDTH  = fbrf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fbrf_pkg::SCREEN_HEIGHT_DEF,
	parameter int AW            = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  fbrf_pkg::cmd_t               cmd,
	output logic                         res_valid,
	input  logic                         res_take,
	output fbrf_pkg::rsp_t               res,
	output logic                         mem_wr_en,
	output logic [AW-1:0]                mem_addr,
	output logic [fbrf_pkg::COLOR_W-1:0] mem_wdata,
	input  logic [fbrf_pkg::COLOR_W-1:0] mem_rdata
);

	localparam int DIM_W  = fbrf_pkg::DIM_W;
	localparam int PROD_W = fbrf_pkg::Y_W + DIM_W;

	localparam logic [DIM_W-1:0] WIDTH_V  = DIM_W'(SCREEN_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_V = DIM_W'(SCREEN_HEIGHT);
	localparam logic [AW-1:0]    ROW_STEP = AW'(SCREEN_WIDTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SETUP  = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_RDISS  = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	fbrf_pkg::cmd_t    cmd_q;
	fbrf_pkg::rsp_t    res_q;
	logic [AW-1:0]     row_q;
	logic [DIM_W-1:0]  x_q;
	logic [DIM_W-1:0]  y_q;
	logic [DIM_W-1:0]  x_start;
	logic [DIM_W-1:0]  y_start;
	logic [DIM_W-1:0]  x_end;
	logic [DIM_W-1:0]  y_end;
	logic [DIM_W-1:0]  x_end_q;
	logic [DIM_W-1:0]  y_end_q;
	logic [DIM_W-1:0]  x_next;
	logic [DIM_W-1:0]  y_next;
	logic [PROD_W-1:0] row_prod;

	// Start point and clipped exclusive end of the rectangle.
	always_comb begin
		x_start  = DIM_W'(cmd_q.left_x);
		y_start  = DIM_W'(cmd_q.top_y);
		x_end    = (DIM_W'(cmd_q.right_x) > WIDTH_V) ? WIDTH_V : DIM_W'(cmd_q.right_x);
		y_end    = (DIM_W'(cmd_q.bottom_y) > HEIGHT_V) ? HEIGHT_V : DIM_W'(cmd_q.bottom_y);
		row_prod = PROD_W'(cmd_q.top_y) * PROD_W'(WIDTH_V);
		x_next   = x_q + 1'b1;
		y_next   = y_q + 1'b1;
	end

	// The address unit: row base plus column, shared by reads and fill writes.
	assign mem_addr  = row_q + AW'(x_q);
	assign mem_wdata = cmd_q.fill_color;
	assign mem_wr_en = (state_q == S_FILL);

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					case (cmd_q.operation)
						fbrf_pkg::OP_READ: begin
							if (x_start >= WIDTH_V || y_start >= HEIGHT_V) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_RDISS;
							end
						end
						fbrf_pkg::OP_FILL: begin
							if (x_start >= x_end || y_start >= y_end) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_FILL;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FILL: begin
					if (x_next == x_end_q && y_next == y_end_q) begin
						state_q <= S_DONE;
					end
				end
				S_RDISS:  state_q <= S_RDWAIT;
				S_RDWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command, walk counters and result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			S_SETUP: begin
				row_q   <= AW'(row_prod);
				x_q     <= x_start;
				y_q     <= y_start;
				x_end_q <= x_end;
				y_end_q <= y_end;
				res_q.command_done <= (cmd_q.operation == fbrf_pkg::OP_READ) ||
					(cmd_q.operation == fbrf_pkg::OP_FILL);
				res_q.read_color   <= '0;
			end
			S_FILL: begin
				if (x_next == x_end_q) begin
					x_q   <= x_start;
					y_q   <= y_next;
					row_q <= row_q + ROW_STEP;
				end else begin
					x_q <= x_next;
				end
			end
			S_RDWAIT: begin
				res_q.read_color <= mem_rdata;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/framebuffer_rect_fill_and_pixel_read.sv */
// Channel  Direction  Payload          Accepted when
// cmd      in         fbrf_pkg::cmd_t  cmd_valid & !cmd_stall
// rsp      out        fbrf_pkg::rsp_t  rsp_valid & !rsp_stall
//
// A read on screen passes the setup, issue and wait states before the response register;
// a fill writes the clipped rectangle one pixel per cycle, set by the single write port
// of the frame memory. Off-screen reads and other commands go from setup to done.
// Reset clears control only; frame memory content is undefined until written.
// The command side stalls while a command is in progress; a response waiting in the
// output register does not hold up the next command.
module framebuffer_rect_fill_and_pixel_read #(
	parameter int SCREEN_WIDTH  = fbrf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fbrf_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  fbrf_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fbrf_pkg::rsp_t rsp
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                         res_valid;
	logic                         res_take;
	fbrf_pkg::rsp_t               res;
	logic                         mem_wr_en;
	logic [AW-1:0]                mem_addr;
	logic [fbrf_pkg::COLOR_W-1:0] mem_wdata;
	logic [fbrf_pkg::COLOR_W-1:0] mem_rdata;
	logic                         rsp_valid_q;
	fbrf_pkg::rsp_t               rsp_q;

	fbrf_seq #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.AW            (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_wr_en (mem_wr_en),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	fbrf_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.wr_en (mem_wr_en),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: takes a finished result when empty or being drained.
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sim/tb.sv */
module tb;

	localparam int SCREEN_W = fbrf_pkg::SCREEN_WIDTH_DEF;
	localparam int SCREEN_H = fbrf_pkg::SCREEN_HEIGHT_DEF;
	localparam int CW = fbrf_pkg::COLOR_W;
	localparam int RANDOM_COMMANDS = 75;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MAX_REPORTS = 10;

	// Code 3 is not defined by the package; the block must treat it as no command.
	localparam logic [fbrf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	// Mirror of the frame memory. It predicts one response per command beat
	// and checks the response beats in order.
	class frame_mirror;
		logic [CW-1:0] pixels [];
		fbrf_pkg::rsp_t expected_rsp [$];
		int mismatches;
		int reads;
		int off_screen_reads;
		int fills;
		int empty_fills;
		int responses;

		function new();
			pixels = new[SCREEN_W * SCREEN_H];
			mismatches = 0;
			reads = 0;
			off_screen_reads = 0;
			fills = 0;
			empty_fills = 0;
			responses = 0;
		endfunction

		function void note_command(fbrf_pkg::cmd_t c);
			fbrf_pkg::rsp_t want;
			int lx;
			int ty;
			int rx;
			int by;
			int x_end;
			int y_end;
			want = '0;
			lx = int'(c.left_x);
			ty = int'(c.top_y);
			rx = int'(c.right_x);
			by = int'(c.bottom_y);
			x_end = (rx > SCREEN_W) ? SCREEN_W : rx;
			y_end = (by > SCREEN_H) ? SCREEN_H : by;
			case (c.operation)
				fbrf_pkg::OP_READ: begin
					want.command_done = 1'b1;
					reads++;
					// Off-screen reads give zero and never wrap into the next row.
					if (lx < SCREEN_W && ty < SCREEN_H)
						want.read_color = pixels[lx + ty * SCREEN_W];
					else
						off_screen_reads++;
				end
				fbrf_pkg::OP_FILL: begin
					want.command_done = 1'b1;
					fills++;
					if (x_end <= lx || y_end <= ty)
						empty_fills++;
					for (int y = ty; y < y_end; y++)
						for (int x = lx; x < x_end; x++)
							pixels[x + y * SCREEN_W] = c.fill_color;
				end
				default: ;
			endcase
			expected_rsp.push_back(want);
		endfunction

		function void report(string field, logic [CW-1:0] want, logic [CW-1:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on response %0d, %s: expected %h, got %h",
					responses, field, want, got);
		endfunction

		function void check_response(fbrf_pkg::rsp_t got);
			fbrf_pkg::rsp_t want;
			responses++;
			if (expected_rsp.size() == 0) begin
				report("response with nothing outstanding", '0, got.read_color);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.command_done !== want.command_done)
				report("command_done", CW'(want.command_done), CW'(got.command_done));
			if (got.read_color !== want.read_color)
				report("read_color", want.read_color, got.read_color);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	fbrf_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	fbrf_pkg::rsp_t rsp;

	frame_mirror board;
	int cycle_count = 0;
	bit gaps_on;
	bit stalls_on;

	framebuffer_rect_fill_and_pixel_read uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hard stop if the block hangs.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("no completion within %0d cycles", CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic fbrf_pkg::cmd_t make_cmd(logic [fbrf_pkg::OP_W-1:0] op, int lx, int ty,
			int rx, int by, logic [CW-1:0] color);
		fbrf_pkg::cmd_t c;
		c.operation = op;
		c.left_x = lx[fbrf_pkg::X_W-1:0];
		c.top_y = ty[fbrf_pkg::Y_W-1:0];
		c.right_x = rx[fbrf_pkg::X_W-1:0];
		c.bottom_y = by[fbrf_pkg::Y_W-1:0];
		c.fill_color = color;
		return c;
	endfunction

	// Present one command beat from a falling edge and hold it until accepted.
	task automatic issue(input fbrf_pkg::cmd_t c);
		int gap;
		gap = gaps_on ? idle_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		board.note_command(c);
	endtask

	// Response side: check accepted beats at the rising edge, change stall at the falling edge.
	initial begin
		int run_left;
		int hold_left;
		rsp_stall = 1'b0;
		run_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				board.check_response(rsp);
			@(negedge clk);
			if (hold_left > 0)
				hold_left--;
			else if (run_left > 0)
				run_left--;
			else if (stalls_on) begin
				hold_left = idle_length();
				run_left = $urandom_range(0, 12);
			end
			rsp_stall = (hold_left > 0);
		end
	end

	initial begin
		int pick;
		int kind;
		int lx;
		int ty;
		int rx;
		int by;
		int hit_x0;
		int hit_y0;
		int hit_x1;
		int hit_y1;
		bit have_hit;
		logic [fbrf_pkg::OP_W-1:0] op;

		board = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		have_hit = 1'b0;
		hit_x0 = 0;
		hit_y0 = 0;
		hit_x1 = 0;
		hit_y1 = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Paint the whole screen first with saturating bounds, so every later read
		// lands on a pixel that has been written.
		issue(make_cmd(fbrf_pkg::OP_FILL, 0, 0, 1023, 511, 32'hFFFF_FFFF));
		issue(make_cmd(fbrf_pkg::OP_READ, 0, 0, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_NONE, 1023, 511, 1023, 511, 32'hFFFF_FFFF));
		issue(make_cmd(OP_UNUSED, 1023, 511, 1023, 511, 32'hFFFF_FFFF));
		// Single pixel in the far corner, then its neighbor to catch an overrun.
		issue(make_cmd(fbrf_pkg::OP_FILL, 639, 479, 640, 480, 32'h0000_0000));
		issue(make_cmd(fbrf_pkg::OP_READ, 639, 479, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 638, 479, 0, 0, 32'h0));
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		// A fill that runs past the right edge must not wrap into the next row.
		issue(make_cmd(fbrf_pkg::OP_FILL, 630, 10, 700, 12, 32'h1234_5678));
		issue(make_cmd(fbrf_pkg::OP_READ, 639, 11, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 0, 12, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 0, 11, 0, 0, 32'h0));
		// Empty rectangles still complete but write nothing.
		issue(make_cmd(fbrf_pkg::OP_FILL, 100, 100, 100, 200, 32'hA5A5_A5A5));
		issue(make_cmd(fbrf_pkg::OP_FILL, 100, 200, 150, 150, 32'h5A5A_5A5A));
		issue(make_cmd(fbrf_pkg::OP_FILL, 640, 0, 1023, 10, 32'hDEAD_BEEF));
		issue(make_cmd(fbrf_pkg::OP_FILL, 0, 480, 10, 511, 32'hDEAD_BEEF));
		issue(make_cmd(fbrf_pkg::OP_READ, 100, 100, 0, 0, 32'h0));
		// Reads off the screen return zero.
		issue(make_cmd(fbrf_pkg::OP_READ, 640, 0, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 0, 480, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 1023, 511, 1023, 511, 32'hFFFF_FFFF));
		issue(make_cmd(fbrf_pkg::OP_FILL, 0, 0, 1, 1, 32'hAAAA_AAAA));
		issue(make_cmd(fbrf_pkg::OP_READ, 0, 0, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_FILL, 0, 479, 640, 480, 32'h5555_5555));
		issue(make_cmd(fbrf_pkg::OP_READ, 320, 479, 0, 0, 32'h0));
		issue(make_cmd(fbrf_pkg::OP_READ, 320, 478, 0, 0, 32'h0));

		// Random commands; fills stay small so the run stays short.
		for (int i = 0; i < RANDOM_COMMANDS; i++) begin
			if (i % 20 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			rx = $urandom_range(0, 1023);
			by = $urandom_range(0, 511);
			if (pick < 45) begin
				op = fbrf_pkg::OP_FILL;
				kind = $urandom_range(0, 9);
				if (kind <= 5) begin
					lx = $urandom_range(0, SCREEN_W - 1);
					ty = $urandom_range(0, SCREEN_H - 1);
					rx = lx + $urandom_range(1, 16);
					by = ty + $urandom_range(1, 16);
					hit_x0 = lx;
					hit_y0 = ty;
					hit_x1 = (rx > SCREEN_W) ? SCREEN_W : rx;
					hit_y1 = (by > SCREEN_H) ? SCREEN_H : by;
					have_hit = 1'b1;
				end else if (kind == 6) begin
					// Clipped against the bottom right corner.
					lx = $urandom_range(620, SCREEN_W - 1);
					ty = $urandom_range(460, SCREEN_H - 1);
					rx = $urandom_range(SCREEN_W, 1023);
					by = $urandom_range(SCREEN_H, 511);
				end else if (kind == 7) begin
					// End at or before the start.
					lx = $urandom_range(0, 1023);
					ty = $urandom_range(0, 511);
					if ($urandom_range(0, 1))
						rx = $urandom_range(0, lx);
					else
						by = $urandom_range(0, ty);
				end else if (kind == 8) begin
					// Start beyond the screen.
					lx = $urandom_range(SCREEN_W, 1023);
					ty = $urandom_range(SCREEN_H, 511);
					if ($urandom_range(0, 1))
						ty = $urandom_range(0, 511);
					else
						lx = $urandom_range(0, 1023);
				end else begin
					// One row with any span.
					lx = $urandom_range(0, 1023);
					ty = $urandom_range(0, 511);
					by = (ty == 511) ? 511 : ty + 1;
				end
			end else if (pick < 85) begin
				op = fbrf_pkg::OP_READ;
				kind = $urandom_range(0, 99);
				if (kind < 50 && have_hit) begin
					lx = $urandom_range(hit_x0, hit_x1 - 1);
					ty = $urandom_range(hit_y0, hit_y1 - 1);
				end else if (kind < 85) begin
					lx = $urandom_range(0, SCREEN_W - 1);
					ty = $urandom_range(0, SCREEN_H - 1);
				end else if ($urandom_range(0, 1)) begin
					lx = $urandom_range(SCREEN_W, 1023);
					ty = $urandom_range(0, 511);
				end else begin
					lx = $urandom_range(0, 1023);
					ty = $urandom_range(SCREEN_H, 511);
				end
			end else begin
				op = (pick < 95) ? fbrf_pkg::OP_NONE : OP_UNUSED;
				lx = $urandom_range(0, 1023);
				ty = $urandom_range(0, 511);
			end
			issue(make_cmd(op, lx, ty, rx, by, $urandom()));
		end

		@(negedge clk);
		cmd_valid = 1'b0;
		stalls_on = 1'b0;

		// Drain outstanding responses, then watch for stray beats.
		while (board.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d fills (%0d empty), %0d reads (%0d off screen), %0d responses checked",
			board.fills, board.empty_fills, board.reads, board.off_screen_reads,
			board.responses);
		$display("%0d mismatches over %0d cycles", board.mismatches, cycle_count);
		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
